/* rtl/core/sdmsp_pkg.sv */
// Package for the discovery stream parser: result kinds, phases, status codes.
// No dependencies.
package sdmsp_pkg;

	localparam int unsigned MIN_HEADER_BYTES = 12;

	typedef enum logic [2:0] {
		KIND_SERVICE    = 3'd0,
		KIND_EVENTGROUP = 3'd1,
		KIND_OPTION     = 3'd2,
		KIND_DONE       = 3'd3,
		KIND_ERROR      = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_ENT_CUT  = 3'd2,
		ST_OLEN_CUT = 3'd3,
		ST_OPT_CUT  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_ENTRIES = 3'd1,
		PH_OPTLEN  = 3'd2,
		PH_OPTIONS = 3'd3,
		PH_TRAIL   = 3'd4
	} phase_t;

	localparam logic [1:0] REG_ENT_EN  = 2'd0;
	localparam logic [1:0] REG_OPT_EN  = 2'd1;
	localparam logic [1:0] REG_ENT_LIM = 2'd2;
	localparam logic [1:0] REG_OPT_LIM = 2'd3;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  code_byte;
		logic [7:0]  index_first;
		logic [7:0]  index_second;
		logic [7:0]  option_counts;
		logic [15:0] svc_id;
		logic [15:0] inst_id;
		logic [7:0]  version_major;
		logic [23:0] ttl;
		logic [31:0] tail_word;
		logic [2:0]  status;
		logic        run_end;
	} result_t;

	typedef struct packed {
		logic    ent_en;
		logic    opt_en;
		logic [15:0] ent_lim;
		logic [15:0] opt_lim;
	} cfg_t;

endpackage

/* rtl/core/sdmsp_parse.sv */
// Parsing datapath: one byte per cycle while take is high, produces up to two results.
// Depends on sdmsp_pkg.
module sdmsp_parse import sdmsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       last,
	input  cfg_t       cfg,
	output logic       r0_ok,
	output logic       r1_ok,
	output result_t    r0,
	output result_t    r1
);

	phase_t      phase_q, phase_d;
	logic [31:0] pos_q;
	logic [7:0]  flags_q;
	logic [32:0] ent_end_q, ent_end_d;
	logic [33:0] opt_end_q, opt_end_d;
	logic [7:0]  ebytes_q [16];
	logic [15:0] ent_seen_q;
	logic [15:0] opt_seen_q;
	logic [16:0] obl_q, obl_d;
	logic [23:0] ohead_q, ohead_d;
	logic [55:0] ecap_q, ecap_d;
	logic        done_q, done_d;
	logic [1:0]  hgot_q, hgot_d;
	logic        oskip_q, oskip_d;
	logic        ent_inc, opt_inc;

	logic [33:0] p1;
	logic [3:0]  slot;
	logic        live;
	result_t     ent_r, opt_r, done_r, err_r, a, b2;
	logic        ent_emit, opt_emit, done_emit;
	logic [15:0] olen_cur;
	logic [16:0] idx;
	logic [31:0] w;
	logic        eg, ep;

	assign live = (pos_q != 32'hFFFF_FFFF);
	assign p1   = {2'b0, pos_q} + 34'd1;
	assign slot = pos_q[3:0] - 4'd8;
	// length field sits above the type byte once both length bytes are in
	assign olen_cur = ohead_q[23:8];
	assign idx = {1'b0, olen_cur} - 17'd1 - obl_q;

	// entry result from the slot bytes with the last byte live
	always_comb begin
		w = {ebytes_q[12], ebytes_q[13], ebytes_q[14], data_byte};
		eg = (ebytes_q[0][2:1] == 2'b11);
		ent_r = '0;
		ent_r.kind = eg ? KIND_EVENTGROUP : KIND_SERVICE;
		ent_r.code_byte = ebytes_q[0];
		ent_r.index_first = ebytes_q[1];
		ent_r.index_second = ebytes_q[2];
		ent_r.option_counts = ebytes_q[3];
		ent_r.svc_id = {ebytes_q[4], ebytes_q[5]};
		ent_r.inst_id = {ebytes_q[6], ebytes_q[7]};
		ent_r.version_major = ebytes_q[8];
		ent_r.ttl = {ebytes_q[9], ebytes_q[10], ebytes_q[11]};
		ent_r.tail_word = eg ? {12'd0, w[19:16], w[15:0]} : w;
	end

	always_comb begin
		phase_d = phase_q; ent_end_d = ent_end_q; opt_end_d = opt_end_q;
		obl_d = obl_q; ohead_d = ohead_q; ecap_d = ecap_q; done_d = done_q;
		hgot_d = hgot_q; oskip_d = oskip_q;
		ent_emit = 1'b0; opt_emit = 1'b0; done_emit = 1'b0;
		ent_inc = 1'b0; opt_inc = 1'b0;
		if (live) begin
			case (phase_q)
				PH_HEADER: begin
					if (pos_q >= 32'd4) ent_end_d = {ent_end_q[24:0], data_byte};
					if (pos_q == 32'd7) begin
						ent_end_d = {ent_end_q[24:0], data_byte} + 33'd8;
						opt_end_d = '0;
						phase_d = ({ent_end_q[23:0], data_byte} == 32'd0) ?
							PH_OPTLEN : PH_ENTRIES;
					end
				end
				PH_ENTRIES: begin
					if (slot == 4'd15 && cfg.ent_en && ent_seen_q < cfg.ent_lim) begin
						ent_inc = 1'b1; ent_emit = 1'b1;
					end
					if (p1 == {1'b0, ent_end_q}) phase_d = PH_OPTLEN;
				end
				PH_OPTLEN: begin
					opt_end_d = {opt_end_q[25:0], data_byte};
					if (p1 == {1'b0, ent_end_q} + 34'd4) begin
						opt_end_d = {1'b0, ent_end_q} + 34'd4 +
							{2'b0, opt_end_q[23:0], data_byte};
						hgot_d = 2'd0; oskip_d = 1'b0;
						if ({opt_end_q[23:0], data_byte} == 32'd0) begin
							done_emit = 1'b1;
						end else phase_d = PH_OPTIONS;
					end
				end
				PH_OPTIONS: begin
					if (!oskip_q) begin
						case (hgot_q)
							2'd0: begin
								if (!cfg.opt_en || opt_seen_q >= cfg.opt_lim ||
									{2'b0, pos_q} + 34'd3 > opt_end_q) begin
									oskip_d = 1'b1;
								end else begin
									opt_inc = 1'b1;
									ohead_d = {data_byte, 16'd0};
									hgot_d = 2'd1;
								end
							end
							2'd1: begin
								ohead_d = {ohead_q[23:16], data_byte, 8'd0};
								hgot_d = 2'd2;
							end
							2'd2: begin
								ohead_d = {ohead_q[23:8], data_byte};
								if (olen_cur == 16'd0) hgot_d = 2'd0;
								else if ({2'b0, pos_q} + {18'd0, olen_cur} > opt_end_q)
									oskip_d = 1'b1;
								else if (olen_cur == 16'd1) begin
									hgot_d = 2'd0; opt_emit = 1'b1;
								end else begin
									obl_d = {1'b0, olen_cur} - 17'd1;
									ecap_d = '0;
									hgot_d = 2'd3;
								end
							end
							default: begin
								case (idx)
									17'd1: ecap_d[55:48] = data_byte;
									17'd2: ecap_d[47:40] = data_byte;
									17'd3: ecap_d[39:32] = data_byte;
									17'd4: ecap_d[31:24] = data_byte;
									17'd6: ecap_d[23:16] = data_byte;
									17'd7: ecap_d[15:8] = data_byte;
									17'd8: ecap_d[7:0] = data_byte;
									default: ;
								endcase
								obl_d = obl_q - 17'd1;
								if (obl_q == 17'd1) begin
									hgot_d = 2'd0; opt_emit = 1'b1;
								end
							end
						endcase
					end
					if (p1 == opt_end_q) done_emit = 1'b1;
				end
				default: ;
			endcase
			if (done_emit) begin
				done_d = 1'b1; phase_d = PH_TRAIL;
			end
		end
	end

	// option result uses the header register after this byte's update
	always_comb begin
		ep = (ohead_d[7:0] == 8'h04 || ohead_d[7:0] == 8'h14 || ohead_d[7:0] == 8'h24)
			&& ohead_d[23:8] >= 16'd10;
		opt_r = '0;
		opt_r.kind = KIND_OPTION;
		opt_r.code_byte = ohead_d[7:0];
		opt_r.svc_id = ohead_d[23:8];
		if (ep) begin
			opt_r.inst_id = ecap_d[15:0];
			opt_r.version_major = ecap_d[23:16];
			opt_r.tail_word = ecap_d[55:24];
		end
		done_r = '0;
		done_r.kind = KIND_DONE;
		done_r.code_byte = flags_q;
		err_r = '0;
		err_r.kind = KIND_ERROR;
		if ({2'b0, pos_q} + 34'd1 < 34'(MIN_HEADER_BYTES) || phase_d == PH_HEADER)
			err_r.status = ST_SHORT;
		else if (phase_d == PH_ENTRIES) err_r.status = ST_ENT_CUT;
		else if (phase_d == PH_OPTLEN) err_r.status = ST_OLEN_CUT;
		else err_r.status = ST_OPT_CUT;
	end

	// pack results in order: entry/option, done, error (two at most)
	logic err_emit, first_any;
	always_comb begin
		err_emit = last && !done_d;
		first_any = ent_emit || opt_emit || done_emit;
		a = ent_emit ? ent_r : (opt_emit ? opt_r : (done_emit ? done_r : err_r));
		b2 = (done_emit && (ent_emit || opt_emit)) ? done_r : err_r;
		r0_ok = first_any || err_emit;
		r1_ok = (first_any && err_emit) ||
			(done_emit && (ent_emit || opt_emit));
		r0 = a; r1 = b2;
		r0.run_end = !r1_ok;
		r1.run_end = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (take && live && phase_q == PH_ENTRIES) ebytes_q[slot] <= data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER; pos_q <= '0; flags_q <= '0;
			ent_end_q <= '0; opt_end_q <= '0; ent_seen_q <= '0; opt_seen_q <= '0;
			obl_q <= '0; ohead_q <= '0; ecap_q <= '0; done_q <= 1'b0;
			hgot_q <= '0; oskip_q <= 1'b0;
		end else if (take) begin
			if (last) begin
				phase_q <= PH_HEADER; pos_q <= '0; flags_q <= '0;
				ent_end_q <= '0; opt_end_q <= '0; ent_seen_q <= '0; opt_seen_q <= '0;
				obl_q <= '0; ohead_q <= '0; ecap_q <= '0; done_q <= 1'b0;
				hgot_q <= '0; oskip_q <= 1'b0;
			end else begin
				phase_q <= phase_d; ent_end_q <= ent_end_d; opt_end_q <= opt_end_d;
				obl_q <= obl_d; ohead_q <= ohead_d; ecap_q <= ecap_d;
				done_q <= done_d; hgot_q <= hgot_d; oskip_q <= oskip_d;
				if (live) pos_q <= pos_q + 32'd1;
				if (live && pos_q == 32'd0 && phase_q == PH_HEADER) flags_q <= data_byte;
				if (ent_inc) ent_seen_q <= ent_seen_q + 16'd1;
				if (opt_inc) opt_seen_q <= opt_seen_q + 16'd1;
			end
		end
	end

endmodule

/* rtl/core/sdmsp_outq.sv */
// Result queue: four-entry FIFO taking up to two results per cycle.
// Depends on sdmsp_pkg.
module sdmsp_outq import sdmsp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push0,
	input  logic    push1,
	input  result_t d0,
	input  result_t d1,
	output logic    room2,
	output logic    valid,
	input  logic    stall,
	output result_t q
);

	result_t     mem_q [4];
	logic [1:0]  rd_q, wr_q;
	logic [2:0]  cnt_q;
	logic        pop;
	logic [2:0]  npush;

	assign valid = (cnt_q != 3'd0);
	assign pop   = valid && !stall;
	assign q     = mem_q[rd_q];
	assign npush = {2'b0, push0} + {2'b0, push1};
	// two free slots before this cycle's pop
	assign room2 = (cnt_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push0) mem_q[wr_q] <= d0;
		if (push1) mem_q[wr_q + 2'd1] <= d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + npush[1:0];
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + npush - {2'b0, pop};
		end
	end

endmodule

/* rtl/core/sd_message_stream_parser.sv */
// Discovery payload parser top level: config registers, parser, result queue.
// Depends on sdmsp_pkg, sdmsp_parse, sdmsp_outq.
// A byte's results are written into the result queue at the clock edge that takes the byte.
// Throughput: one byte per cycle while in_stall is low; a byte may cause two results, drained one per
// cycle while out_stall is low from a four-deep queue, which is what limits sustained rate.
// Reset: asynchronous; registers return to enabled, limits 65535, parser to header.
module sd_message_stream_parser import sdmsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  code_byte,
	output logic [7:0]  index_first,
	output logic [7:0]  index_second,
	output logic [7:0]  option_counts,
	output logic [15:0] svc_id,
	output logic [15:0] inst_id,
	output logic [7:0]  version_major,
	output logic [23:0] ttl,
	output logic [31:0] tail_word,
	output logic [2:0]  status,
	output logic        run_end
);

	cfg_t    cfg_q;
	logic    take, r0_ok, r1_ok, room2;
	result_t r0, r1, head;

	// registers written whenever enabled, read live by the parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{ent_en: 1'b1, opt_en: 1'b1, ent_lim: 16'hFFFF, opt_lim: 16'hFFFF};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENT_EN:  cfg_q.ent_en  <= cfg_data[0];
				REG_OPT_EN:  cfg_q.opt_en  <= cfg_data[0];
				REG_ENT_LIM: cfg_q.ent_lim <= cfg_data;
				REG_OPT_LIM: cfg_q.opt_lim <= cfg_data;
				default: ;
			endcase
		end
	end

	// a byte is taken only when the queue can hold both results it may cause
	assign in_stall = !room2;
	assign take     = in_valid && room2;

	sdmsp_parse u_parse (
		.clk, .arst_n, .take, .data_byte, .last, .cfg(cfg_q),
		.r0_ok, .r1_ok, .r0, .r1
	);

	sdmsp_outq u_outq (
		.clk, .arst_n,
		.push0(take && r0_ok), .push1(take && r1_ok),
		.d0(r0), .d1(r1), .room2, .valid(out_valid), .stall(out_stall), .q(head)
	);

	assign kind          = head.kind;
	assign code_byte     = head.code_byte;
	assign index_first   = head.index_first;
	assign index_second  = head.index_second;
	assign option_counts = head.option_counts;
	assign svc_id        = head.svc_id;
	assign inst_id       = head.inst_id;
	assign version_major = head.version_major;
	assign ttl           = head.ttl;
	assign tail_word     = head.tail_word;
	assign status        = head.status;
	assign run_end       = head.run_end;

endmodule

/* sim/tb_sd_message_stream_parser.sv */
// Testbench for sd_message_stream_parser: directed table plus random discovery payloads,
// every result checked against a behavioural parser model held in this file.
// Depends on sdmsp_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_sd_message_stream_parser;
	import sdmsp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  kind;
	logic [7:0]  code_byte;
	logic [7:0]  index_first;
	logic [7:0]  index_second;
	logic [7:0]  option_counts;
	logic [15:0] svc_id;
	logic [15:0] inst_id;
	logic [7:0]  version_major;
	logic [23:0] ttl;
	logic [31:0] tail_word;
	logic [2:0]  status;
	logic        run_end;

	sd_message_stream_parser uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .code_byte(code_byte), .index_first(index_first),
		.index_second(index_second), .option_counts(option_counts),
		.svc_id(svc_id), .inst_id(inst_id),
		.version_major(version_major), .ttl(ttl), .tail_word(tail_word),
		.status(status), .run_end(run_end)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Parser model: own copy of config and per-message state
	// ---------------------------------------------------------------
	logic        m_ent_en, m_opt_en;
	logic [15:0] m_ent_lim, m_opt_lim;

	phase_t      m_phase;
	logic [32:0] m_pos;       // wide enough to saturate at 2^32-1
	logic [7:0]  m_flags;
	logic [33:0] m_ent_end;
	logic [33:0] m_opt_end;
	logic [7:0]  m_slot [16];
	logic [15:0] m_ent_cnt, m_opt_cnt;
	logic [16:0] m_opt_left;
	logic [23:0] m_opt_head;
	logic [55:0] m_ep;
	logic        m_done;
	int unsigned m_head_got;
	logic        m_opt_skip;

	result_t     expected_q[$];
	int          n_fail;
	result_t     m_last_first;  // first result of the latest byte
	int          m_last_n;      // number of results of the latest byte

	task automatic new_message();
		m_phase    = PH_HEADER;
		m_pos      = '0;
		m_flags    = '0;
		m_ent_end  = '0;
		m_opt_end  = '0;
		for (int i = 0; i < 16; i++) m_slot[i] = '0;
		m_ent_cnt  = '0;
		m_opt_cnt  = '0;
		m_opt_left = '0;
		m_opt_head = '0;
		m_ep       = '0;
		m_done     = 1'b0;
		m_head_got = 0;
		m_opt_skip = 1'b0;
	endtask

	function automatic result_t blank_result(kind_t k);
		result_t r;
		r      = '0;
		r.kind = k;
		return r;
	endfunction

	task automatic push_entry(ref result_t res[$]);
		result_t     r;
		logic [31:0] w;
		logic        eg;
		w  = {m_slot[12], m_slot[13], m_slot[14], m_slot[15]};
		eg = (m_slot[0] & 8'h06) == 8'h06;
		r  = blank_result(eg ? KIND_EVENTGROUP : KIND_SERVICE);
		r.code_byte     = m_slot[0];
		r.index_first   = m_slot[1];
		r.index_second  = m_slot[2];
		r.option_counts = m_slot[3];
		r.svc_id        = {m_slot[4], m_slot[5]};
		r.inst_id       = {m_slot[6], m_slot[7]};
		r.version_major = m_slot[8];
		r.ttl           = {m_slot[9], m_slot[10], m_slot[11]};
		r.tail_word     = eg ? {12'h000, w[19:16], w[15:0]} : w;
		res.insert(res.size(), r);
	endtask

	task automatic push_option(ref result_t res[$]);
		result_t     r;
		logic [15:0] len;
		logic [7:0]  typ;
		len = m_opt_head[23:8];
		typ = m_opt_head[7:0];
		r   = blank_result(KIND_OPTION);
		r.code_byte = typ;
		r.svc_id    = len;
		if ((typ == 8'h04 || typ == 8'h14 || typ == 8'h24) && len >= 16'd10) begin
			r.inst_id       = m_ep[15:0];
			r.version_major = m_ep[23:16];
			r.tail_word     = m_ep[55:24];
		end
		res.insert(res.size(), r);
	endtask

	task automatic push_done(ref result_t res[$]);
		result_t r;
		r = blank_result(KIND_DONE);
		r.code_byte = m_flags;
		res.insert(res.size(), r);
		m_done  = 1'b1;
		m_phase = PH_TRAIL;
	endtask

	task automatic option_step(logic [33:0] p, logic [7:0] b, ref result_t res[$]);
		logic [15:0] len;
		int unsigned idx;
		if (m_opt_skip) return;
		if (m_head_got == 0) begin
			if (!m_opt_en || m_opt_cnt >= m_opt_lim || p + 3 > m_opt_end) begin
				m_opt_skip = 1'b1;
				return;
			end
			m_opt_cnt++;
			m_opt_head = {b, 16'h0000};
			m_head_got = 1;
		end else if (m_head_got == 1) begin
			m_opt_head[15:8] = b;
			m_head_got = 2;
		end else if (m_head_got == 2) begin
			m_opt_head[7:0] = b;
			len = m_opt_head[23:8];
			if (len == 0) begin
				m_head_got = 0;
			end else if (p + len > m_opt_end) begin
				m_opt_skip = 1'b1;
			end else if (len == 1) begin
				m_head_got = 0;
				push_option(res);
			end else begin
				m_opt_left = 17'(len - 1);
				m_ep       = '0;
				m_head_got = 3;
			end
		end else begin
			// data byte index within the option body
			idx = (m_opt_head[23:8] - 1) - m_opt_left;
			if (idx >= 1 && idx <= 4)
				m_ep[24 + 8 * (4 - idx) +: 8] = b;
			else if (idx == 6)
				m_ep[23:16] = b;
			else if (idx == 7)
				m_ep[15:8] = b;
			else if (idx == 8)
				m_ep[7:0] = b;
			m_opt_left--;
			if (m_opt_left == 0) begin
				m_head_got = 0;
				push_option(res);
			end
		end
	endtask

	// Works out the results one payload byte causes and queues them.
	task automatic parse_byte(logic [7:0] b, logic lst);
		result_t     res[$];
		result_t     r;
		logic [33:0] p;
		logic [33:0] olen;
		p = m_pos;
		if (p < 34'hFFFF_FFFF) begin
			case (m_phase)
			PH_HEADER: begin
				if (p == 0)
					m_flags = b;
				else if (p >= 4)
					m_ent_end = {m_ent_end[25:0], b};
				if (p == 7) begin
					m_ent_end = m_ent_end + 8;
					m_opt_end = '0;
					m_phase   = (m_ent_end == 8) ? PH_OPTLEN : PH_ENTRIES;
				end
			end
			PH_ENTRIES: begin
				m_slot[(p - 8) & 15] = b;
				if (((p - 8) & 15) == 15 && m_ent_en && m_ent_cnt < m_ent_lim) begin
					m_ent_cnt++;
					push_entry(res);
				end
				if (p + 1 == m_ent_end) m_phase = PH_OPTLEN;
			end
			PH_OPTLEN: begin
				m_opt_end = {m_opt_end[25:0], b};
				if (p + 1 == m_ent_end + 4) begin
					olen       = {2'b00, m_opt_end[31:0]};
					m_opt_end  = m_ent_end + 4 + olen;
					m_head_got = 0;
					m_opt_skip = 1'b0;
					if (olen == 0)
						push_done(res);
					else
						m_phase = PH_OPTIONS;
				end
			end
			PH_OPTIONS: begin
				option_step(p, b, res);
				if (p + 1 == m_opt_end) push_done(res);
			end
			default: ;
			endcase
			m_pos = 33'(p + 1);
		end
		if (lst && !m_done) begin
			r = blank_result(KIND_ERROR);
			if (p + 1 < MIN_HEADER_BYTES || m_phase == PH_HEADER) r.status = ST_SHORT;
			else if (m_phase == PH_ENTRIES) r.status = ST_ENT_CUT;
			else if (m_phase == PH_OPTLEN) r.status = ST_OLEN_CUT;
			else r.status = ST_OPT_CUT;
			res.insert(res.size(), r);
		end
		if (res.size() > 0) res[res.size() - 1].run_end = 1'b1;
		m_last_n = res.size();
		if (res.size() > 0) m_last_first = res[0];
		foreach (res[i]) expected_q.insert(expected_q.size(), res[i]);
		if (lst) new_message();
	endtask

	// ---------------------------------------------------------------
	// Driving
	// ---------------------------------------------------------------
	int unsigned burst_left;
	logic        idle_pattern;  // 0 turns off sender gaps for a stretch
	logic        hold_off;      // long receiver stall, set by the stimulus
	int          stall_mode;

	// Offers one byte, waits for acceptance, and updates the model.
	// Valid stays high after the item; a gap or drain lowers it.
	task automatic send_byte(logic [7:0] b, logic lst);
		if (idle_pattern) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last      <= lst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		parse_byte(b, lst);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_ENT_EN:  m_ent_en  = val[0];
		REG_OPT_EN:  m_opt_en  = val[0];
		REG_ENT_LIM: m_ent_lim = val;
		default:     m_opt_lim = val;
		endcase
		@(negedge clk);
	endtask

	// Stops offering and waits until every expected result has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Receiver stall pattern: random, sometimes none, sometimes a long hold.
	initial begin
		out_stall  = 1'b0;
		stall_mode = 0;
		forever begin
			@(negedge clk);
			if (hold_off)
				out_stall <= 1'b1;
			else if (stall_mode == 0)
				out_stall <= 1'b0;
			else if (stall_mode == 1)
				out_stall <= ($urandom_range(0, 3) == 0);
			else
				out_stall <= ($urandom_range(0, 1) == 0);
			if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
		end
	end

	// Result checker
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: kind %0d", kind);
				n_fail++;
			end else begin
				exp_r = expected_q.pop_front();
				if (kind !== exp_r.kind) begin
					$error("kind exp %0d got %0d", exp_r.kind, kind); n_fail++; end
				if (code_byte !== exp_r.code_byte) begin
					$error("code_byte exp %0h got %0h", exp_r.code_byte, code_byte); n_fail++; end
				if (index_first !== exp_r.index_first) begin
					$error("index_first exp %0h got %0h", exp_r.index_first, index_first);
					n_fail++; end
				if (index_second !== exp_r.index_second) begin
					$error("index_second exp %0h got %0h", exp_r.index_second, index_second);
					n_fail++; end
				if (option_counts !== exp_r.option_counts) begin
					$error("option_counts exp %0h got %0h", exp_r.option_counts, option_counts);
					n_fail++; end
				if (svc_id !== exp_r.svc_id) begin
					$error("svc_id exp %0h got %0h", exp_r.svc_id, svc_id);
					n_fail++; end
				if (inst_id !== exp_r.inst_id) begin
					$error("inst_id exp %0h got %0h", exp_r.inst_id, inst_id);
					n_fail++; end
				if (version_major !== exp_r.version_major) begin
					$error("version_major exp %0h got %0h", exp_r.version_major, version_major);
					n_fail++; end
				if (ttl !== exp_r.ttl) begin
					$error("ttl exp %0h got %0h", exp_r.ttl, ttl); n_fail++; end
				if (tail_word !== exp_r.tail_word) begin
					$error("tail_word exp %0h got %0h", exp_r.tail_word, tail_word); n_fail++; end
				if (status !== exp_r.status) begin
					$error("status exp %0d got %0d", exp_r.status, status); n_fail++; end
				if (run_end !== exp_r.run_end) begin
					$error("run_end exp %0b got %0b", exp_r.run_end, run_end); n_fail++; end
			end
		end
	end

	// Timeout: well above the slowest legal run
	int unsigned cycle_count;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	// Directed table: byte, last, and an optional fixed expectation for the
	// first result of that byte (checked against the model's own prediction).
	typedef struct {
		logic [7:0] b;
		logic       lst;
		logic       fixed;
		kind_t      fk;
		status_t    fs;
	} row_t;

	row_t         rows[$];
	int unsigned  sent;
	logic [7:0]   msg[$];

	task automatic add_row(logic [7:0] b, logic lst, logic fixed, kind_t fk, status_t fs);
		row_t r;
		r.b = b; r.lst = lst; r.fixed = fixed; r.fk = fk; r.fs = fs;
		rows.insert(rows.size(), r);
	endtask

	// Builds a payload with random content into msg; it is sometimes malformed or cut short.
	task automatic build_message(int n_ent, int n_opt);
		int unsigned elen, olen, start;
		logic [7:0]  t;
		int unsigned l;
		msg.delete();
		msg.insert(msg.size(), 8'($urandom_range(0, 255)));
		repeat (3) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
		elen = 16 * n_ent + (($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0);
		msg.insert(msg.size(), elen[31:24]); msg.insert(msg.size(), elen[23:16]);
		msg.insert(msg.size(), elen[15:8]);  msg.insert(msg.size(), elen[7:0]);
		for (int i = 0; i < elen; i++) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
		start = msg.size();
		repeat (4) msg.insert(msg.size(), 8'h00);
		for (int i = 0; i < n_opt; i++) begin
			case ($urandom_range(0, 4))
			0: t = 8'h04;
			1: t = 8'h14;
			2: t = 8'h24;
			default: t = 8'($urandom_range(0, 255));
			endcase
			l = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 10;
			msg.insert(msg.size(), 8'h00); msg.insert(msg.size(), l[7:0]);
			msg.insert(msg.size(), t);
			for (int j = 0; j < l; j++) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
		end
		olen = msg.size() - start - 4;
		if ($urandom_range(0, 9) == 0) olen = olen + $urandom_range(0, 6) - 3;
		msg[start]     = olen[31:24]; msg[start + 1] = olen[23:16];
		msg[start + 2] = olen[15:8];  msg[start + 3] = olen[7:0];
		repeat ($urandom_range(0, 2)) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
		// occasionally cut short
		if ($urandom_range(0, 9) == 0) msg = msg[0:$urandom_range(0, msg.size() - 1)];
	endtask

	task automatic send_message();
		for (int i = 0; i < msg.size(); i++) begin
			send_byte(msg[i], i == msg.size() - 1);
			sent++;
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_ENT_EN;
		cfg_data     = '0;
		in_valid     = 1'b0;
		data_byte    = '0;
		last         = 1'b0;
		hold_off     = 1'b0;
		idle_pattern = 1'b0;
		burst_left   = 0;
		n_fail       = 0;
		sent         = 0;
		cycle_count  = 0;
		m_last_n     = 0;
		m_last_first = '0;
		m_ent_en     = 1'b1;
		m_opt_en     = 1'b1;
		m_ent_lim    = 16'hFFFF;
		m_opt_lim    = 16'hFFFF;
		new_message();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: a too short buffer, then a message with one service entry that is
		// cut short in the options length field.
		add_row(8'hFF, 1'b1, 1'b1, KIND_ERROR, ST_SHORT);
		add_row(8'hC0, 1'b0, 1'b0, KIND_DONE, ST_OK);
		repeat (6) add_row(8'h00, 1'b0, 1'b0, KIND_DONE, ST_OK);
		add_row(8'h10, 1'b0, 1'b0, KIND_DONE, ST_OK);          // one entry
		add_row(8'h01, 1'b0, 1'b0, KIND_DONE, ST_OK);          // service type
		for (int i = 1; i < 15; i++) add_row(8'hFF, 1'b0, 1'b0, KIND_DONE, ST_OK);
		add_row(8'h80, 1'b0, 1'b1, KIND_SERVICE, ST_OK);
		add_row(8'h00, 1'b1, 1'b1, KIND_ERROR, ST_OLEN_CUT);   // cut in options length
		for (int i = 0; i < rows.size(); i++) begin
			send_byte(rows[i].b, rows[i].lst);
			if (rows[i].fixed && (m_last_n == 0 ||
			    m_last_first.kind != rows[i].fk ||
			    m_last_first.status != rows[i].fs)) begin
				$error("directed row %0d: kind exp %0d got %0d, status exp %0d got %0d",
					i, rows[i].fk, m_last_first.kind, rows[i].fs, m_last_first.status);
				n_fail++;
			end
		end
		// Special shapes: zero length option, option crossing the end,
		// eventgroup entry with trailing bytes.
		msg = '{8'h40, 0, 0, 0, 0, 0, 0, 8'h14,
			8'h06, 1, 2, 8'h21, 8'hAB, 8'hCD, 8'h12, 8'h34, 1, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 9, 9, 9, 9,
			0, 0, 0, 8'h0A, 0, 0, 8'h04, 0, 0, 8'h40, 8'h04, 0, 0, 8'h01};
		send_message();
		drain();

		// Random phases over several register settings, extremes included.
		idle_pattern = 1'b1;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
			1: begin write_reg(REG_ENT_EN, 16'h0000); write_reg(REG_OPT_EN, 16'h0000); end
			2: begin write_reg(REG_ENT_EN, 16'h0001); write_reg(REG_OPT_EN, 16'h0001);
				write_reg(REG_ENT_LIM, 16'h0000); write_reg(REG_OPT_LIM, 16'h0000); end
			3: begin write_reg(REG_ENT_LIM, 16'h0001); write_reg(REG_OPT_LIM, 16'h0002); end
			4: begin write_reg(REG_ENT_LIM, 16'hFFFF); write_reg(REG_OPT_LIM, 16'hFFFF); end
			5: write_reg(REG_OPT_EN, 16'hFFFE);
			6: begin write_reg(REG_OPT_EN, 16'h0001);
				write_reg(REG_ENT_LIM, 16'($urandom_range(0, 3)));
				write_reg(REG_OPT_LIM, 16'($urandom_range(0, 3))); end
			7: begin write_reg(REG_ENT_LIM, 16'hFFFF); write_reg(REG_OPT_LIM, 16'hFFFF); end
			default: ;
			endcase
			idle_pattern = (ph != 4);
			if (ph == 3) begin
				// long receiver hold while the sender keeps offering
				hold_off = 1'b1;
				fork
					begin repeat (300) @(negedge clk); hold_off = 1'b0; end
					begin build_message(3, 3); send_message(); end
				join
			end
			while (sent < 240 * (ph + 1)) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise bytes ending the buffer at random
					repeat ($urandom_range(1, 20)) begin
						send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
						sent++;
					end
					send_byte(8'($urandom_range(0, 255)), 1'b1);
					sent++;
				end else begin
					build_message($urandom_range(0, 4), $urandom_range(0, 4));
					send_message();
				end
			end
			drain();
		end

		if (n_fail == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/sdmsp_pkg.sv
rtl/core/sdmsp_parse.sv
rtl/core/sdmsp_outq.sv
rtl/core/sd_message_stream_parser.sv
sim/tb_sd_message_stream_parser.sv
